[hdl/dti_pkg.sv]
// ----------------------------------------------------------------------------
// dti_pkg
// Shared sizes, codes and types for the decision tree inference unit.
// ----------------------------------------------------------------------------
package dti_pkg;

  // Table sizes and word widths
  localparam int NODE_COUNT  = 512;
  localparam int NODE_AW     = $clog2(NODE_COUNT);
  localparam int FEAT_COUNT  = 64;
  localparam int FEAT_AW     = $clog2(FEAT_COUNT);
  localparam int LEVEL_LIMIT = 16;
  localparam int LVL_W       = $clog2(LEVEL_LIMIT + 1);
  localparam int VALUE_BITS  = 32;
  localparam int WORD_BITS   = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_NODE_WR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FEAT_WR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_PRESENT = 1'd1;

  // One node table entry
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] threshold;
    logic [WORD_BITS-1:0]         leaf_word;
    logic [FEAT_AW-1:0]           attr;
    logic                         eq_test;
    logic                         leaf;
    logic [NODE_AW-1:0]           left;
    logic [NODE_AW-1:0]           right;
  } node_t;

  // Controller to datapath commands
  typedef struct packed {
    logic node_wr;
    logic feat_wr;
    logic walk_start;
    logic node_rd;
    logic feat_rd;
    logic step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tree_present;
    logic node_leaf;
    logic at_limit;
  } status_t;

endpackage

[hdl/dti_datapath.sv]
// ----------------------------------------------------------------------------
// dti_datapath
// Node and feature memories, walk registers, threshold compare, config
// registers and the result register.
// ----------------------------------------------------------------------------
module dti_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dti_pkg::cmd_t                         cmd_i,
  output dti_pkg::status_t                      status_o,
  input  logic                                  cfg_we_i,
  input  logic [dti_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dti_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [dti_pkg::NODE_AW-1:0]           node_index_i,
  input  logic [dti_pkg::FEAT_AW-1:0]           feature_index_i,
  input  logic signed [dti_pkg::VALUE_BITS-1:0] value_i,
  input  logic signed [dti_pkg::WORD_BITS-1:0]  leaf_word_i,
  input  logic [dti_pkg::FEAT_AW-1:0]           attr_select_i,
  input  logic                                  equality_test_i,
  input  logic                                  is_leaf_i,
  input  logic [dti_pkg::NODE_AW-1:0]           left_child_i,
  input  logic [dti_pkg::NODE_AW-1:0]           right_child_i,
  output logic signed [dti_pkg::WORD_BITS-1:0]  result_word_o,
  output logic                                  walk_error_o,
  output logic [dti_pkg::LVL_W-1:0]             levels_walked_o
);
  import dti_pkg::*;

  node_t                  node_mem [NODE_COUNT];
  logic signed [VALUE_BITS-1:0] feat_mem [FEAT_COUNT];

  node_t                  node_q;
  logic signed [VALUE_BITS-1:0] feat_q;
  logic [NODE_AW-1:0]     root_q;
  logic                   tree_q;
  logic [NODE_AW-1:0]     cur_q, cur_d;
  logic [LVL_W-1:0]       levels_q, levels_d;
  logic                   holds;
  logic [NODE_AW-1:0]     next_cur;
  logic [NODE_AW-1:0]     node_rd_addr;
  node_t                  node_wr_data;

  logic signed [WORD_BITS-1:0] res_word_q, res_word_d;
  logic                        res_err_q, res_err_d;
  logic [LVL_W-1:0]            res_lvl_q, res_lvl_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      tree_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROOT_NODE:    root_q <= cfg_data_i[NODE_AW-1:0];
        CFG_TREE_PRESENT: tree_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Assemble a node entry from the input item
  always_comb begin
    node_wr_data.threshold = value_i;
    node_wr_data.leaf_word = leaf_word_i;
    node_wr_data.attr      = attr_select_i;
    node_wr_data.eq_test   = equality_test_i;
    node_wr_data.leaf      = is_leaf_i;
    node_wr_data.left      = left_child_i;
    node_wr_data.right     = right_child_i;
  end

  // Threshold test and next node
  assign holds    = node_q.eq_test ? (feat_q == node_q.threshold)
                                   : (feat_q > node_q.threshold);
  assign next_cur = holds ? node_q.right : node_q.left;
  assign node_rd_addr = cmd_i.step ? next_cur : cur_q;

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.node_wr) begin
      node_mem[node_index_i] <= node_wr_data;
    end
    if (cmd_i.node_rd) begin
      node_q <= node_mem[node_rd_addr];
    end
  end

  // Feature memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_wr) begin
      feat_mem[feature_index_i] <= value_i;
    end
    if (cmd_i.feat_rd) begin
      feat_q <= feat_mem[node_q.attr];
    end
  end

  // Walk position and level count
  always_comb begin
    cur_d    = cur_q;
    levels_d = levels_q;
    if (cmd_i.walk_start) begin
      cur_d    = root_q;
      levels_d = '0;
    end else if (cmd_i.step) begin
      cur_d    = next_cur;
      levels_d = levels_q + LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      levels_q <= '0;
    end else begin
      cur_q    <= cur_d;
      levels_q <= levels_d;
    end
  end

  // Result: leaf word, zero with error at the limit, zero without a tree
  always_comb begin
    res_word_d = '0;
    res_err_d  = 1'b0;
    res_lvl_d  = '0;
    if (tree_q) begin
      res_lvl_d = levels_q;
      if (node_q.leaf) begin
        res_word_d = node_q.leaf_word;
      end else begin
        res_err_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_word_q <= res_word_d;
      res_err_q  <= res_err_d;
      res_lvl_q  <= res_lvl_d;
    end
  end

  assign result_word_o   = res_word_q;
  assign walk_error_o    = res_err_q;
  assign levels_walked_o = res_lvl_q;

  assign status_o.tree_present = tree_q;
  assign status_o.node_leaf    = node_q.leaf;
  assign status_o.at_limit     = (levels_q == LVL_W'(LEVEL_LIMIT));

endmodule

[hdl/dti_ctrl.sv]
// ----------------------------------------------------------------------------
// dti_ctrl
// Sequencer for requests: table writes, tree walk and result handoff.
// ----------------------------------------------------------------------------
module dti_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dti_pkg::MODE_W-1:0] mode_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  dti_pkg::status_t           status_i,
  output dti_pkg::cmd_t              cmd_o
);
  import dti_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NODE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_NODE_WR: cmd_o.node_wr = 1'b1;
            MODE_FEAT_WR: cmd_o.feat_wr = 1'b1;
            MODE_EVAL: begin
              if (status_i.tree_present) begin
                cmd_o.walk_start = 1'b1;
                state_d          = S_NODE;
              end else begin
                state_d = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_NODE: begin
        cmd_o.node_rd = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.node_leaf || status_i.at_limit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.feat_rd = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.step    = 1'b1;
        cmd_o.node_rd = 1'b1;
        state_d       = S_CHECK;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_cmp_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |=> state_q == S_CHECK)
    else $error("compare step did not return to node check");

  a_check_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && (status_i.node_leaf || status_i.at_limit))
      |=> state_q == S_DONE)
    else $error("walk did not end at leaf or level limit");

  a_no_tree_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_EVAL && !status_i.tree_present)
      |=> state_q == S_DONE)
    else $error("evaluate without tree did not go to result");
`endif

endmodule

[hdl/decision_tree_inference_unit.sv]
// ----------------------------------------------------------------------------
// decision_tree_inference_unit
// Decision tree inference over a 512-entry node table and 64 feature slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per transfer:
//   mode 0 writes a node entry, mode 1 writes a feature slot, mode 2
//   evaluates the stored features; mode 3 is dropped. Writes give no result.
//   An evaluate walks from root_node: it reads the root node, then for each
//   inner node reads and compares its feature and steps to the next node,
//   until a leaf or 16 levels; the result then goes to the result register.
//   Without a loaded tree it returns zero.
//   Output channel (out_valid_o / out_stall_i) carries one result per
//   evaluate. The result register holds while the receiver stalls; the unit
//   keeps taking writes meanwhile, and a new evaluate waits at its end until
//   the register is free.
//   Configuration (cfg_valid_i / cfg_ready_o): index 0 root_node, index 1
//   tree_present; write only while idle. Reset clears both to zero and
//   empties the result register; node and feature memories are not cleared.
// ----------------------------------------------------------------------------
module decision_tree_inference_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [dti_pkg::MODE_W-1:0]            mode_i,
  input  logic [dti_pkg::NODE_AW-1:0]           node_index_i,
  input  logic [dti_pkg::FEAT_AW-1:0]           feature_index_i,
  input  logic signed [dti_pkg::VALUE_BITS-1:0] value_i,
  input  logic signed [dti_pkg::WORD_BITS-1:0]  leaf_word_i,
  input  logic [dti_pkg::FEAT_AW-1:0]           attr_select_i,
  input  logic                                  equality_test_i,
  input  logic                                  is_leaf_i,
  input  logic [dti_pkg::NODE_AW-1:0]           left_child_i,
  input  logic [dti_pkg::NODE_AW-1:0]           right_child_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [dti_pkg::WORD_BITS-1:0]  result_word_o,
  output logic                                  walk_error_o,
  output logic [dti_pkg::LVL_W-1:0]             levels_walked_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dti_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dti_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import dti_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  dti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dti_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .node_index_i    (node_index_i),
    .feature_index_i (feature_index_i),
    .value_i         (value_i),
    .leaf_word_i     (leaf_word_i),
    .attr_select_i   (attr_select_i),
    .equality_test_i (equality_test_i),
    .is_leaf_i       (is_leaf_i),
    .left_child_i    (left_child_i),
    .right_child_i   (right_child_i),
    .result_word_o   (result_word_o),
    .walk_error_o    (walk_error_o),
    .levels_walked_o (levels_walked_o)
  );

endmodule
